// ----- hw/rtl/hrsp_pkg.sv -----
// hrsp_pkg: shared types, constants and helpers of the hex record stream parser
// no dependencies; used by hrsp_core and hex_record_stream_parser_top
package hrsp_pkg;

  // event codes carried on the result stream
  typedef enum logic [1:0] {
    EV_WRITE     = 2'd0,
    EV_LINE_ACK  = 2'd1,
    EV_START_ACK = 2'd2,
    EV_FINISH    = 2'd3
  } event_kind_t;

  // configuration register indexes
  localparam logic [1:0] CFG_LINE_END      = 2'd0;
  localparam logic [1:0] CFG_SESSION_START = 2'd1;
  localparam logic [1:0] CFG_SESSION_END   = 2'd2;

  // configuration reset values
  localparam logic [7:0] LINE_END_RESET      = 8'd10;
  localparam logic [7:0] SESSION_START_RESET = 8'd2;
  localparam logic [7:0] SESSION_END_RESET   = 8'd4;

  // record layout
  localparam logic [7:0] POS_COUNT_HI = 8'd1;
  localparam logic [7:0] POS_COUNT_LO = 8'd2;
  localparam logic [7:0] POS_ADDR_LO  = 8'd3;
  localparam logic [7:0] POS_ADDR_HI  = 8'd6;
  localparam logic [7:0] POS_TYPE     = 8'd8;
  localparam logic [7:0] POS_DATA     = 8'd9;
  localparam logic [7:0] POS_EXT_LAST = 8'd12;
  localparam logic [7:0] POS_MAX      = 8'd255;

  // record types handled
  localparam logic [3:0] REC_DATA     = 4'd0;
  localparam logic [3:0] REC_EXT_ADDR = 4'd4;

  // delimiter characters as seen by the core
  typedef struct packed {
    logic [7:0] line_end_char;
    logic [7:0] session_start_char;
    logic [7:0] session_end_char;
  } delim_cfg_t;

  // one result item
  typedef struct packed {
    event_kind_t kind;
    logic [31:0] write_address;
    logic [15:0] write_halfword;
  } event_t;

  // upper-case hex digit value, anything else decodes as zero
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'd48 && c <= 8'd57) begin
      v = 4'(c - 8'd48);
    end else if (c >= 8'd65 && c <= 8'd70) begin
      v = 4'(c - 8'd55);
    end
    return v;
  endfunction

endpackage

// ----- hw/rtl/hex_record_stream_parser_top.sv -----
// hex_record_stream_parser_top: stream wrapper with delimiter registers and output register
// depends on hrsp_pkg and hrsp_core
//
// Parses a hex record text stream one character per input transfer and emits
// halfword flash writes (with byte address), line acknowledges, session start
// acknowledges and a finished event. The parser state updates at the input
// transfer and the event, if any, lands in the output register at that same
// edge, so a new character is accepted every cycle as long as the output
// register is empty or being drained. After the finished event all characters
// are swallowed until reset. The user must set delimiter characters through the
// write port only while the stream is idle; the block itself does not enforce this.
module hex_record_stream_parser_top (
  input  logic        clk,
  input  logic        rst,
  // character input
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_in
  // event output
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [31:0] write_address, [47:32] write_halfword
  output logic [1:0]  m_tuser,   // [1:0] event_kind
  // configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import hrsp_pkg::*;

  delim_cfg_t cfg;
  logic       in_xfer;
  logic       ev_valid;
  event_t     ev;
  logic       out_valid;
  event_t     out_ev;

  assign s_tready = !out_valid || m_tready;
  assign in_xfer  = s_tvalid && s_tready;

  // delimiter registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.line_end_char      <= LINE_END_RESET;
      cfg.session_start_char <= SESSION_START_RESET;
      cfg.session_end_char   <= SESSION_END_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LINE_END:      cfg.line_end_char      <= cfg_data;
        CFG_SESSION_START: cfg.session_start_char <= cfg_data;
        CFG_SESSION_END:   cfg.session_end_char   <= cfg_data;
        default: ;
      endcase
    end
  end

  hrsp_core u_core (
    .clk      (clk),
    .rst      (rst),
    .step     (in_xfer),
    .char_in  (s_tdata),
    .cfg      (cfg),
    .ev_valid (ev_valid),
    .ev       (ev)
  );

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer) begin
      out_valid <= ev_valid;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (in_xfer && ev_valid) begin
      out_ev <= ev;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_ev.write_halfword, out_ev.write_address};
  assign m_tuser  = out_ev.kind;

endmodule

// ----- hw/rtl/hrsp_core.sv -----
// hrsp_core: parser state and per-character update, one character per transfer
// depends on hrsp_pkg
module hrsp_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic [7:0]         char_in,
  input  hrsp_pkg::delim_cfg_t cfg,
  output logic               ev_valid,
  output hrsp_pkg::event_t   ev
);
  import hrsp_pkg::*;

  logic [7:0]  char_position, char_position_next;
  logic [7:0]  byte_count, byte_count_next;
  logic [3:0]  record_kind, record_kind_next;
  logic [15:0] upper_address, upper_address_next;
  logic [15:0] lower_address, lower_address_next;
  logic [11:0] digit_holder, digit_holder_next;
  logic [6:0]  halfword_index, halfword_index_next;
  logic        finished_flag, finished_flag_next;

  logic [3:0]  d;
  logic [1:0]  grp;
  logic [6:0]  half_count;
  logic [31:0] halfword_addr;

  assign d          = hex_value(char_in);
  assign grp        = char_position[1:0] - 2'd1;
  assign half_count = byte_count[7:1];
  assign halfword_addr = {upper_address, lower_address} + {24'd0, halfword_index, 1'b0};

  // next state and event for the accepted character
  always_comb begin
    char_position_next  = char_position;
    byte_count_next     = byte_count;
    record_kind_next    = record_kind;
    upper_address_next  = upper_address;
    lower_address_next  = lower_address;
    digit_holder_next   = digit_holder;
    halfword_index_next = halfword_index;
    finished_flag_next  = finished_flag;
    ev_valid            = 1'b0;
    ev                  = '{kind: EV_WRITE, write_address: 32'd0, write_halfword: 16'd0};
    if (step && !finished_flag) begin
      if (char_in == cfg.session_start_char) begin
        char_position_next  = 8'd0;
        digit_holder_next   = 12'd0;
        halfword_index_next = 7'd0;
        ev_valid            = 1'b1;
        ev.kind             = EV_START_ACK;
      end else if (char_in == cfg.line_end_char) begin
        char_position_next  = 8'd0;
        digit_holder_next   = 12'd0;
        halfword_index_next = 7'd0;
        ev_valid            = 1'b1;
        ev.kind             = EV_LINE_ACK;
      end else if (char_in == cfg.session_end_char) begin
        finished_flag_next = 1'b1;
        ev_valid           = 1'b1;
        ev.kind            = EV_FINISH;
      end else if (char_position != POS_MAX) begin
        char_position_next = char_position + 8'd1;
        if (char_position == POS_COUNT_HI) begin
          byte_count_next = {d, 4'd0};
        end else if (char_position == POS_COUNT_LO) begin
          byte_count_next = {byte_count[7:4], d};
        end else if (char_position >= POS_ADDR_LO && char_position <= POS_ADDR_HI) begin
          lower_address_next = {lower_address[11:0], d};
        end else if (char_position == POS_TYPE) begin
          record_kind_next = d;
        end else if (char_position >= POS_DATA) begin
          if (record_kind == REC_EXT_ADDR) begin
            // extended address record: four digits form the upper half
            if (char_position == POS_EXT_LAST) begin
              upper_address_next = {digit_holder, d};
              lower_address_next = 16'd0;
            end else if (char_position < POS_EXT_LAST) begin
              digit_holder_next = {digit_holder[7:0], d};
            end
          end else if (record_kind == REC_DATA) begin
            if (grp == 2'd3) begin
              // fourth digit of a byte pair completes a little-endian halfword
              if (halfword_index < half_count) begin
                ev_valid            = 1'b1;
                ev.write_address    = halfword_addr;
                ev.write_halfword   = {digit_holder[3:0], d, digit_holder[11:8],
                                       digit_holder[7:4]};
                halfword_index_next = halfword_index + 7'd1;
              end
            end else begin
              // odd trailing byte padded with 0xff in the high byte
              if (grp == 2'd1 && byte_count[0] && halfword_index == half_count) begin
                ev_valid            = 1'b1;
                ev.write_address    = halfword_addr;
                ev.write_halfword   = {8'hFF, digit_holder[3:0], d};
                halfword_index_next = halfword_index + 7'd1;
              end
              if (grp == 2'd0) begin
                digit_holder_next = {8'd0, d};
              end else begin
                digit_holder_next = {digit_holder[7:0], d};
              end
            end
          end
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      char_position  <= 8'd0;
      byte_count     <= 8'd0;
      record_kind    <= 4'd0;
      upper_address  <= 16'd0;
      lower_address  <= 16'd0;
      digit_holder   <= 12'd0;
      halfword_index <= 7'd0;
      finished_flag  <= 1'b0;
    end else begin
      char_position  <= char_position_next;
      byte_count     <= byte_count_next;
      record_kind    <= record_kind_next;
      upper_address  <= upper_address_next;
      lower_address  <= lower_address_next;
      digit_holder   <= digit_holder_next;
      halfword_index <= halfword_index_next;
      finished_flag  <= finished_flag_next;
    end
  end

endmodule

// ----- bench/hex_record_stream_parser_top_tb.sv -----
// hex_record_stream_parser_top_tb: self-checking bench for the hex record stream parser
// depends on hrsp_pkg and hex_record_stream_parser_top; drives characters, checks events
// a local line-position predictor computes every event, which is compared in order
module hex_record_stream_parser_top_tb;
  import hrsp_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;      // [7:0] char_in
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;             // [31:0] write_address, [47:32] write_halfword
  logic [1:0]  m_tuser;             // [1:0] event_kind
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_LINE_END;
  logic [7:0]  cfg_data = 8'd0;

  hex_record_stream_parser_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #1 clk = ~clk;

  // delimiter copies and parser state of the predictor
  logic [7:0]  delim_line  = LINE_END_RESET;
  logic [7:0]  delim_start = SESSION_START_RESET;
  logic [7:0]  delim_stop  = SESSION_END_RESET;
  logic [7:0]  line_pos    = 8'd0;
  logic [7:0]  byte_total  = 8'd0;
  logic [3:0]  rec_type    = 4'd0;
  logic [15:0] addr_upper  = 16'd0;
  logic [15:0] addr_lower  = 16'd0;
  logic [11:0] nibbles     = 12'd0;
  logic [6:0]  half_done   = 7'd0;
  logic        download_over = 1'b0;

  event_t      events_due[$];
  logic [7:0]  chars_to_send[$];
  logic [7:0]  record_text[$];
  int          chars_queued = 0;
  int          mismatches = 0;
  int          quiet_cycles = 0;
  int          hold_left = 0;
  bit          hold_asked = 1'b0;
  bit          steady = 1'b0;

  // upper-case hex digit value, anything else is zero
  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return c[3:0];
    if (c >= "A" && c <= "F") return c[3:0] + 4'd9;
    return 4'd0;
  endfunction

  function void restart_line();
    line_pos  = 8'd0;
    nibbles   = 12'd0;
    half_done = 7'd0;
  endfunction

  // advance the parser by one character; returns 1 when an event results
  function bit parse_char(input logic [7:0] c, output event_t ev);
    logic [7:0]  pos;
    logic [7:0]  off;
    logic [3:0]  d;
    logic [1:0]  grp;
    logic [6:0]  pairs;
    logic [31:0] base;
    bit          hit;
    ev  = '0;
    hit = 1'b0;
    if (download_over) return 1'b0;
    // delimiters, session start first, then line end, then session end
    if (c == delim_start) begin
      restart_line();
      ev.kind = EV_START_ACK;
      return 1'b1;
    end
    if (c == delim_line) begin
      restart_line();
      ev.kind = EV_LINE_ACK;
      return 1'b1;
    end
    if (c == delim_stop) begin
      download_over = 1'b1;
      ev.kind = EV_FINISH;
      return 1'b1;
    end
    pos = line_pos;
    if (pos == POS_MAX) return 1'b0;
    line_pos = pos + 8'd1;
    d     = nibble_of(c);
    off   = pos - POS_DATA;
    grp   = off[1:0];
    pairs = byte_total[7:1];
    base  = {addr_upper, addr_lower};
    if (pos == POS_COUNT_HI) begin
      byte_total = {d, 4'd0};
    end else if (pos == POS_COUNT_LO) begin
      byte_total[3:0] = d;
    end else if (pos >= POS_ADDR_LO && pos <= POS_ADDR_HI) begin
      addr_lower = {addr_lower[11:0], d};
    end else if (pos == POS_TYPE) begin
      rec_type = d;
    end else if (pos >= POS_DATA) begin
      if (rec_type == REC_EXT_ADDR) begin
        // extended address: four digits form the upper half
        if (pos == POS_EXT_LAST) begin
          addr_upper = {nibbles, d};
          addr_lower = 16'd0;
        end else if (pos < POS_EXT_LAST) begin
          nibbles = {nibbles[7:0], d};
        end
      end else if (rec_type == REC_DATA) begin
        if (grp == 2'd3) begin
          // fourth digit completes a little-endian halfword
          if (half_done < pairs) begin
            ev.kind           = EV_WRITE;
            ev.write_address  = base + {24'd0, half_done, 1'b0};
            ev.write_halfword = {nibbles[3:0], d, nibbles[11:8], nibbles[7:4]};
            half_done = half_done + 7'd1;
            hit = 1'b1;
          end
        end else begin
          // odd trailing byte is padded with 0xFF in the high byte
          if (grp == 2'd1 && byte_total[0] && half_done == pairs) begin
            ev.kind           = EV_WRITE;
            ev.write_address  = base + {24'd0, half_done, 1'b0};
            ev.write_halfword = {8'hFF, nibbles[3:0], d};
            half_done = half_done + 7'd1;
            hit = 1'b1;
          end
          if (grp == 2'd0) nibbles = {8'd0, d};
          else nibbles = {nibbles[7:0], d};
        end
      end
    end
    return hit;
  endfunction

  // character source: holds each offer until the transfer, idles at random
  always @(posedge clk) begin : feed_chars
    event_t ev;
    logic   took;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      took = s_tvalid && s_tready;
      if (took) begin
        if (parse_char(s_tdata, ev)) events_due.push_back(ev);
      end
      if (!s_tvalid || took) begin
        if (chars_to_send.size() != 0 && (steady || $urandom_range(0, 99) >= 17)) begin
          s_tvalid <= 1'b1;
          s_tdata  <= chars_to_send.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // event sink: compares each transfer with the oldest predicted event
  always @(posedge clk) begin : check_events
    event_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (events_due.size() == 0) begin
          $display("%0t: unexpected event: expected none, actual kind %0d addr %h half %h",
                   $time, m_tuser, m_tdata[31:0], m_tdata[47:32]);
          mismatches++;
        end else begin
          want = events_due.pop_front();
          if (m_tuser !== want.kind) begin
            $display("%0t: event_kind mismatch: expected %0d, actual %0d",
                     $time, want.kind, m_tuser);
            mismatches++;
          end
          if (m_tdata[31:0] !== want.write_address) begin
            $display("%0t: write_address mismatch: expected %h, actual %h",
                     $time, want.write_address, m_tdata[31:0]);
            mismatches++;
          end
          if (m_tdata[47:32] !== want.write_halfword) begin
            $display("%0t: write_halfword mismatch: expected %h, actual %h",
                     $time, want.write_halfword, m_tdata[47:32]);
            mismatches++;
          end
        end
      end
      // long hold-off on request, else random stalls
      if (hold_asked) begin
        hold_asked = 1'b0;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= steady || ($urandom_range(0, 99) >= 17);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("hex_record_stream_parser_top test failed");
        $finish;
      end
    end
  end

  // queue one character, steering clear of an unintended session end
  task automatic send_char(input logic [7:0] c);
    if (c == delim_stop && c != delim_start && c != delim_line) c = c ^ 8'h01;
    chars_to_send.push_back(c);
    chars_queued++;
  endtask

  // append n hex digits of v, now and then a garbled one
  task automatic add_hex(input logic [15:0] v, input int n);
    logic [3:0] nib;
    int         i;
    for (i = n - 1; i >= 0; i--) begin
      nib = v[4*i +: 4];
      if ($urandom_range(0, 99) < 3) begin
        record_text.push_back(8'($urandom_range(0, 255)));
      end else begin
        record_text.push_back(nib < 4'd10 ? 8'd48 + 8'(nib) : 8'd55 + 8'(nib));
      end
    end
  endtask

  // one record line; a broken one may be cut short and may end in a session start
  task automatic send_record(input logic [3:0] kind, input logic [7:0] count, input bit broken);
    int i;
    int cut;
    record_text.delete();
    record_text.push_back(":");
    add_hex(16'(count), 2);
    add_hex(16'($urandom_range(0, 65535)), 4);
    if ($urandom_range(0, 99) < 5) record_text.push_back(8'($urandom_range(0, 255)));
    else record_text.push_back("0");
    add_hex(16'(kind), 1);
    for (i = 0; i < count; i++) add_hex(16'($urandom_range(0, 255)), 2);
    if ($urandom_range(0, 99) < 5) add_hex(16'($urandom_range(0, 65535)), 4);
    add_hex(16'($urandom_range(0, 255)), 2);
    cut = broken ? $urandom_range(1, record_text.size()) : record_text.size();
    for (i = 0; i < cut; i++) send_char(record_text[i]);
    if (broken && $urandom_range(0, 3) == 0) send_char(delim_start);
    else send_char(delim_line);
  endtask

  // mostly well-formed records with random content, some noise and broken lines
  task automatic send_random(input int budget);
    int         base;
    int         roll;
    int         i;
    logic [7:0] count;
    logic [3:0] kind;
    bit         broken;
    base = chars_queued;
    while (chars_queued - base < budget) begin
      roll   = $urandom_range(0, 99);
      broken = $urandom_range(0, 99) < 12;
      if (roll < 8) begin
        for (i = $urandom_range(1, 6); i > 0; i--) send_char(8'($urandom_range(0, 255)));
      end else if (roll < 11) begin
        send_char(delim_start);
      end else if (roll < 21) begin
        send_record(REC_EXT_ADDR, 8'd2, broken);
      end else if (roll < 28) begin
        kind = 4'($urandom_range(1, 15));
        if (kind == REC_EXT_ADDR) kind = kind + 4'd1;
        send_record(kind, 8'($urandom_range(0, 4)), broken);
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 85) count = 8'($urandom_range(0, 16));
        else if (roll < 99) count = 8'($urandom_range(17, 48));
        else count = 8'($urandom_range(100, 255));
        send_record(REC_DATA, count, broken);
      end
    end
  endtask

  // wait until every character is taken and every event has arrived
  task automatic drain();
    while (chars_to_send.size() != 0 || s_tvalid || events_due.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(input logic [1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_LINE_END:      delim_line  = val;
      CFG_SESSION_START: delim_start = val;
      CFG_SESSION_END:   delim_stop  = val;
      default: ;
    endcase
  endtask

  task automatic write_delims(input logic [7:0] line_val, input logic [7:0] start_val,
                              input logic [7:0] stop_val);
    set_reg(CFG_LINE_END, line_val);
    set_reg(CFG_SESSION_START, start_val);
    set_reg(CFG_SESSION_END, stop_val);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int i;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset delimiters: session start, odd-length data record, stray characters
    send_char(SESSION_START_RESET);
    send_char(":");
    send_char("0"); send_char("3");
    send_char("1"); send_char("2"); send_char("F"); send_char("E");
    send_char("0"); send_char("0");
    send_char("A"); send_char("5"); send_char("C"); send_char("3");
    send_char("9"); send_char("F");
    send_char(LINE_END_RESET);
    send_char(8'h00); send_char(8'hFF); send_char("a"); send_char("G");
    send_char(LINE_END_RESET);
    send_random(230);
    hold_asked = 1'b1;
    drain();

    // extreme delimiters and one line long enough to saturate the position
    write_delims(8'h00, 8'hFF, 8'hFE);
    send_char(delim_start);
    send_record(REC_DATA, 8'hFF, 1'b0);
    send_random(230);
    drain();

    // line end shares its code with session end and wins; no idling here
    write_delims(8'hFF, 8'h00, 8'hFF);
    steady = 1'b1;
    send_random(230);
    drain();
    steady = 1'b0;

    // session start shares its code with session end and wins
    write_delims(8'h0D, 8'h1B, 8'h1B);
    send_random(230);
    drain();

    // finish the download, then everything is swallowed
    write_delims(LINE_END_RESET, SESSION_START_RESET, SESSION_END_RESET);
    send_random(60);
    chars_to_send.push_back(delim_stop);
    chars_to_send.push_back(delim_start);
    chars_to_send.push_back(delim_line);
    chars_to_send.push_back(delim_stop);
    for (i = 0; i < 30; i++) chars_to_send.push_back(8'($urandom_range(0, 255)));
    drain();

    if (mismatches == 0) begin
      $display("hex_record_stream_parser_top test passed");
    end else begin
      $display("hex_record_stream_parser_top test failed");
    end
    $finish;
  end

endmodule
